### design/svalloc_pkg.sv
package svalloc_pkg;

  localparam int unsigned CHANNELS_DEF = 8;

  localparam int unsigned ENT_W    = 12;
  localparam int unsigned SUB_W    = 4;
  localparam int unsigned SND_W    = 9;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CHAN_W   = 3;

  // APB: one register at byte address 0, data bus 32 bits
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_PLAYER = 1'b0;   // paddr[2] value of register 0

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STOP  = 1'b1;

  localparam logic [SUB_W-1:0] SUB_NONE = 4'h0;
  localparam logic [SUB_W-1:0] SUB_ANY  = 4'hF;

  localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SILENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOCHAN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [TIME_W-1:0] LIFE_LIMIT = 32'h7fff_ffff;
  localparam logic [TIME_W-1:0] SIGN_FLIP  = 32'h8000_0000;
  localparam logic [TIME_W-1:0] KEY_INIT   = LIFE_LIMIT ^ SIGN_FLIP;

  typedef struct packed {
    logic [ENT_W-1:0]  owner;
    logic [SUB_W-1:0]  sub;
    logic [SND_W-1:0]  sound;
    logic              active;
    logic [TIME_W-1:0] end_time;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch request, reset scan state
    logic rd_en;    // read table entry at rd_addr
    logic eval;     // data read last cycle is valid for the scan
    logic load;     // commit table write and load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;      // entry under evaluation ends the scan
  } stat_t;

endpackage

### design/svalloc_ctrl.sv
module svalloc_ctrl #(
  parameter int unsigned CHANNELS = svalloc_pkg::CHANNELS_DEF,
  parameter int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  svalloc_pkg::stat_t  stat_i,
  output svalloc_pkg::cmd_t   cmd_o,
  output logic [IdxW-1:0]     rd_addr_o
);
  import svalloc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(CHANNELS - 1);

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            pend_q;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          idx_d        = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.eval  = pend_q;
        if (pend_q && stat_i.hit) begin
          state_d = S_FIN;
        end else if (idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        cmd_o.eval = pend_q;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= cmd_o.rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  assign rd_addr_o   = idx_q;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/svalloc_dp.sv
module svalloc_dp #(
  parameter int unsigned CHANNELS = svalloc_pkg::CHANNELS_DEF,
  parameter int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  svalloc_pkg::cmd_t                  cmd_i,
  output svalloc_pkg::stat_t                 stat_o,
  input  logic [IdxW-1:0]                    rd_addr_i,
  input  logic [svalloc_pkg::ENT_W-1:0]      player_i,
  input  logic                               req_type_i,
  input  logic [svalloc_pkg::ENT_W-1:0]      entity_i,
  input  logic signed [svalloc_pkg::SUB_W-1:0] sub_channel_i,
  input  logic [svalloc_pkg::SND_W-1:0]      sound_id_i,
  input  logic [svalloc_pkg::LEN_W-1:0]      length_i,
  input  logic                               playable_i,
  input  logic [svalloc_pkg::TIME_W-1:0]     now_i,
  output logic [svalloc_pkg::STATUS_W-1:0]   status_o,
  output logic [svalloc_pkg::CHAN_W-1:0]     channel_o
);
  import svalloc_pkg::*;

  // request latched at accept
  logic              req_q;
  logic [ENT_W-1:0]  ent_q;
  logic [SUB_W-1:0]  sub_q;
  logic [SND_W-1:0]  snd_q;
  logic [LEN_W-1:0]  len_q;
  logic              play_q;
  logic [TIME_W-1:0] now_q;

  // table
  entry_t            mem [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  entry_t            rdata_q;
  logic              rvld_q;
  logic [IdxW-1:0]   ridx_q;

  // scan state
  logic [TIME_W-1:0] best_q;
  logic [IdxW-1:0]   pick_q;
  logic              pick_vld_q;
  logic              hit_q;
  logic [IdxW-1:0]   hit_idx_q;
  entry_t            hold_q;

  logic [STATUS_W-1:0] status_q;
  logic [CHAN_W-1:0]   channel_q;

  entry_t            ent_e;
  logic              start_hit, stop_hit, skip, better;
  logic [TIME_W-1:0] key;

  logic              tgt_vld;
  logic [IdxW-1:0]   tgt;
  logic [IdxW+CHAN_W-1:0] tgt_ext;
  entry_t            wr_entry;
  logic [STATUS_W-1:0] status_d;
  logic [CHAN_W-1:0]   channel_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= req_type_i;
      ent_q  <= entity_i;
      sub_q  <= sub_channel_i;
      snd_q  <= sound_id_i;
      len_q  <= length_i;
      play_q <= playable_i;
      now_q  <= now_i;
    end
  end

  // never-written entries read as zero
  assign ent_e = rvld_q ? rdata_q : '0;

  always_comb begin
    start_hit = (sub_q != SUB_NONE) && (ent_e.owner == ent_q) &&
                ((ent_e.sub == sub_q) || (sub_q == SUB_ANY));
    stop_hit  = (ent_e.owner == ent_q) && (ent_e.sub == sub_q);
    skip      = (ent_e.owner == player_i) && (ent_q != player_i) && ent_e.active;
    key       = (ent_e.end_time - now_q) ^ SIGN_FLIP;
    better    = (req_q == REQ_START) && !skip && (key < best_q);
    stat_o.hit = cmd_i.eval && ((req_q == REQ_STOP) ? stop_hit : start_hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      pick_vld_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        hit_q      <= 1'b0;
        pick_vld_q <= 1'b0;
      end else if (cmd_i.eval) begin
        if (stat_o.hit) begin
          hit_q <= 1'b1;
        end else if (better) begin
          pick_vld_q <= 1'b1;
        end
      end
      if (cmd_i.load && tgt_vld) begin
        valid_q[tgt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      best_q <= KEY_INIT;
    end else if (cmd_i.eval) begin
      if (stat_o.hit) begin
        hit_idx_q <= ridx_q;
        hold_q    <= ent_e;
      end else if (better) begin
        best_q <= key;
        pick_q <= ridx_q;
      end
    end
  end

  // target entry, new contents and result
  always_comb begin
    tgt_vld  = hit_q || pick_vld_q;
    tgt      = hit_q ? hit_idx_q : pick_q;
    tgt_ext  = {{CHAN_W{1'b0}}, tgt};
    wr_entry = '0;
    if (req_q == REQ_STOP) begin
      wr_entry.owner = hold_q.owner;
      wr_entry.sub   = hold_q.sub;
      wr_entry.sound = hold_q.sound;
      status_d       = hit_q ? ST_STOPPED : ST_NOTFOUND;
    end else begin
      wr_entry.owner = ent_q;
      wr_entry.sub   = sub_q;
      if (play_q) begin
        wr_entry.sound    = snd_q;
        wr_entry.active   = 1'b1;
        wr_entry.end_time = now_q + {{(TIME_W-LEN_W){1'b0}}, len_q};
      end
      if (!tgt_vld) begin
        status_d = ST_NOCHAN;
      end else begin
        status_d = play_q ? ST_STARTED : ST_SILENT;
      end
    end
    channel_d = tgt_vld ? tgt_ext[CHAN_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
      rvld_q  <= valid_q[rd_addr_i];
      ridx_q  <= rd_addr_i;
    end
    if (cmd_i.load && tgt_vld) begin
      mem[tgt] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q  <= status_d;
      channel_q <= channel_d;
    end
  end

  assign status_o  = status_q;
  assign channel_o = channel_q;

endmodule

### design/sound_voice_allocator.sv
// Voice allocator: one request beat in, one result beat out.
// A request is accepted only while idle and is then scanned entry by entry; the
// result is registered once the scan ends and the output is free, and no new
// request is taken until then.
// An unmatched start or stop scans the whole table; a match ends the scan.
// Reset (async, active low) empties the table and clears player_entity.
module sound_voice_allocator #(
  parameter int unsigned CHANNELS = svalloc_pkg::CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [svalloc_pkg::PADDR_W-1:0]      paddr,
  input  logic [svalloc_pkg::PDATA_W-1:0]      pwdata,
  output logic [svalloc_pkg::PDATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [svalloc_pkg::ENT_W-1:0]        entity_i,
  input  logic signed [svalloc_pkg::SUB_W-1:0] sub_channel_i,
  input  logic [svalloc_pkg::SND_W-1:0]        sound_id_i,
  input  logic [svalloc_pkg::LEN_W-1:0]        length_i,
  input  logic                                 playable_i,
  input  logic [svalloc_pkg::TIME_W-1:0]       now_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [svalloc_pkg::STATUS_W-1:0]     status_o,
  output logic [svalloc_pkg::CHAN_W-1:0]       channel_o
);
  import svalloc_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ENT_W-1:0] player_q;
  cmd_t             cmd;
  stat_t            stat;
  logic [IdxW-1:0]  rd_addr;

  // register file
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PLAYER)) begin
      player_q <= pwdata[ENT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PLAYER: prdata = {{(PDATA_W-ENT_W){1'b0}}, player_q};
      default:    prdata = '0;
    endcase
  end

  svalloc_ctrl #(
    .CHANNELS (CHANNELS),
    .IdxW     (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  svalloc_dp #(
    .CHANNELS (CHANNELS),
    .IdxW     (IdxW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rd_addr_i     (rd_addr),
    .player_i      (player_q),
    .req_type_i    (req_type_i),
    .entity_i      (entity_i),
    .sub_channel_i (sub_channel_i),
    .sound_id_i    (sound_id_i),
    .length_i      (length_i),
    .playable_i    (playable_i),
    .now_i         (now_i),
    .status_o      (status_o),
    .channel_o     (channel_o)
  );

  // a request beat keeps the block busy on the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while not busy afterwards");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_STARTED || status_o == ST_SILENT ||
                     status_o == ST_NOCHAN || status_o == ST_STOPPED ||
                     status_o == ST_NOTFOUND))
    else $error("result status out of range");

  a_no_entry_chan0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_NOCHAN || status_o == ST_NOTFOUND))
      |-> (channel_o == '0))
    else $error("channel not zero without an entry");

  // a new result is only loaded while the block is still busy with a request
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> in_stall_o)
    else $error("result loaded while idle");

endmodule
